// ===== hw/rtl/bytecode_short_stack_alu_core_unit_assert.svh =====
// assertion macros for the bytecode stack alu core
// used by the top level only, no other dependencies
`ifndef BYTECODE_SHORT_STACK_ALU_CORE_UNIT_ASSERT_SVH
`define BYTECODE_SHORT_STACK_ALU_CORE_UNIT_ASSERT_SVH

// implication checked on every clock unless in reset
`define BSA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked unless in reset
`define BSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/bsa_pkg.sv =====
// package for the bytecode stack alu core: types, codes, opcode classifier
// no dependencies
package bsa_pkg;

    localparam int unsigned DataW   = 16;
    localparam int unsigned OpW     = 8;
    localparam int unsigned LimW    = 7;
    localparam int unsigned StatusW = 3;

    // status codes
    localparam logic [StatusW-1:0] ST_OK    = 3'd0;
    localparam logic [StatusW-1:0] ST_UNDER = 3'd1;
    localparam logic [StatusW-1:0] ST_OVER  = 3'd2;
    localparam logic [StatusW-1:0] ST_DIV0  = 3'd3;
    localparam logic [StatusW-1:0] ST_LOCAL = 3'd4;
    localparam logic [StatusW-1:0] ST_UNSUP = 3'd5;

    // opcodes with special meaning
    localparam logic [OpW-1:0] OP_BSPUSH = 8'd16;
    localparam logic [OpW-1:0] OP_SSPUSH = 8'd17;
    localparam logic [OpW-1:0] OP_SADD   = 8'd65;
    localparam logic [OpW-1:0] OP_SSUB   = 8'd67;
    localparam logic [OpW-1:0] OP_SMUL   = 8'd69;
    localparam logic [OpW-1:0] OP_SDIV   = 8'd71;
    localparam logic [OpW-1:0] OP_SREM   = 8'd73;
    localparam logic [OpW-1:0] OP_SNEG   = 8'd75;
    localparam logic [OpW-1:0] OP_SSHL   = 8'd77;
    localparam logic [OpW-1:0] OP_SSHR   = 8'd79;
    localparam logic [OpW-1:0] OP_SUSHR  = 8'd81;
    localparam logic [OpW-1:0] OP_SAND   = 8'd83;
    localparam logic [OpW-1:0] OP_SOR    = 8'd85;
    localparam logic [OpW-1:0] OP_SINC   = 8'd89;
    localparam logic [OpW-1:0] OP_S2B    = 8'd91;
    localparam logic [OpW-1:0] OP_GOTO   = 8'd112;
    localparam logic [OpW-1:0] OP_SINCW  = 8'd150;
    localparam logic [OpW-1:0] OP_GOTOW  = 8'd168;

    localparam logic [4:0] SHIFT_MASK = 5'h1F;

    // kinds of instruction
    typedef enum logic [3:0] {
        K_NOP, K_PUSHC, K_LOAD, K_STORE, K_POP, K_DUP, K_DUP2, K_BIN, K_NEG,
        K_S2B, K_INC, K_IF1, K_IF2, K_GOTO, K_BAD
    } t_kind;

    // classified instruction passed from front to back
    typedef struct packed {
        t_kind            kind;
        logic [OpW-1:0]   op;
        logic [7:0]       slot;
        logic [2:0]       cond;
        logic [2:0]       pops;
        logic [2:0]       pushes;
        logic [DataW-1:0] val;
        logic [DataW-1:0] off;
    } t_instr;

    // result beat
    typedef struct packed {
        logic [StatusW-1:0] status;
        logic               branch_taken;
        logic [DataW-1:0]   branch_offset;
        logic [DataW-1:0]   top_value;
        logic [LimW-1:0]    depth_after;
    } t_result;

    function automatic logic [DataW-1:0] sx8(input logic [DataW-1:0] v);
        return {{(DataW-8){v[7]}}, v[7:0]};
    endfunction

    // opcode decode into kind, counts and constants
    function automatic t_instr classify(input logic [OpW-1:0] op,
                                        input logic [DataW-1:0] imm,
                                        input logic [7:0] li);
        t_instr r;
        r = '0;
        r.kind = K_BAD;
        r.op = op;
        if (op == 8'd0) r.kind = K_NOP;
        else if (op >= 8'd1 && op <= 8'd8) begin
            r.kind = K_PUSHC;
            r.val = (op == 8'd1) ? '0 : DataW'(op) - DataW'(3);
        end else if (op == OP_BSPUSH) begin
            r.kind = K_PUSHC; r.val = sx8(imm);
        end else if (op == OP_SSPUSH) begin
            r.kind = K_PUSHC; r.val = imm;
        end else if (op == 8'd21 || op == 8'd22) begin
            r.kind = K_LOAD; r.slot = li;
        end else if (op >= 8'd24 && op <= 8'd31) begin
            r.kind = K_LOAD; r.slot = {6'd0, op[1:0]};
        end else if (op == 8'd40 || op == 8'd41) begin
            r.kind = K_STORE; r.slot = li;
        end else if (op >= 8'd43 && op <= 8'd50) begin
            r.kind = K_STORE; r.slot = {6'd0, 2'(op - 8'd43)};
        end else if (op == 8'd59) begin
            r.kind = K_POP; r.pops = 3'd1;
        end else if (op == 8'd60) begin
            r.kind = K_POP; r.pops = 3'd2;
        end else if (op == 8'd61) begin
            r.kind = K_DUP; r.pops = 3'd1; r.pushes = 3'd2;
        end else if (op == 8'd62) begin
            r.kind = K_DUP2; r.pops = 3'd2; r.pushes = 3'd4;
        end else if (op == OP_SNEG) begin
            r.kind = K_NEG; r.pops = 3'd1; r.pushes = 3'd1;
        end else if (op >= 8'd65 && op <= 8'd87 && op[0]) begin
            r.kind = K_BIN; r.pops = 3'd2; r.pushes = 3'd1;
        end else if (op == OP_SINC) begin
            r.kind = K_INC; r.slot = li; r.val = sx8(imm);
        end else if (op == OP_SINCW) begin
            r.kind = K_INC; r.slot = li; r.val = imm;
        end else if (op == OP_S2B) begin
            r.kind = K_S2B; r.pops = 3'd1; r.pushes = 3'd1;
        end else if (op >= 8'd96 && op <= 8'd103) begin
            r.kind = K_IF1; r.cond = op[2:0]; r.off = sx8(imm);
        end else if (op >= 8'd104 && op <= 8'd111) begin
            r.kind = K_IF2; r.cond = 3'(op - 8'd104); r.off = sx8(imm);
        end else if (op == OP_GOTO) begin
            r.kind = K_GOTO; r.off = sx8(imm);
        end else if (op >= 8'd152 && op <= 8'd159) begin
            r.kind = K_IF1; r.cond = op[2:0]; r.off = imm;
        end else if (op >= 8'd160 && op <= 8'd167) begin
            r.kind = K_IF2; r.cond = op[2:0]; r.off = imm;
        end else if (op == OP_GOTOW) begin
            r.kind = K_GOTO; r.off = imm;
        end
        if (r.kind == K_PUSHC || r.kind == K_LOAD) r.pushes = 3'd1;
        if (r.kind == K_STORE || r.kind == K_IF1) r.pops = 3'd1;
        if (r.kind == K_IF2) r.pops = 3'd2;
        return r;
    endfunction

endpackage

// ===== hw/rtl/bsa_if.sv =====
// valid/ready channel interface carrying one payload
// no dependencies
interface bsa_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/bytecode_short_stack_alu_core_unit.sv =====
// Top of the bytecode short operand-stack ALU core.
// Back end steps: idle, rd1, rd2, exec; on an error exec goes straight to top. Otherwise mul,
// div and rem wait in md for the iterative unit, each push is written in wr, then rdt and top.
// One instruction at a time in the back end, the next starts once the result beat is taken.
// Reset (synchronous, active low) empties stack and queue, clears locals via valid bits, limits 64.
module bytecode_short_stack_alu_core_unit #(
    parameter int unsigned STACK_DEPTH  = 64,
    parameter int unsigned LOCALS_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bsa_if.sink         in_ch,
    bsa_if.source       out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bsa_pkg::*;

    localparam logic [2:0] ADDR_STACK_LIMIT  = 3'd0;
    localparam logic [2:0] ADDR_LOCALS_LIMIT = 3'd4;

    logic [6:0] r_stack_limit, r_locals_limit;
    logic       q_valid, q_pop, busy;
    t_instr     q_instr;
    t_result    res;

    assign pready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stack_limit  <= 7'd64;
            r_locals_limit <= 7'd64;
        end else if (psel && penable && pwrite) begin
            if (paddr == ADDR_STACK_LIMIT) r_stack_limit <= pwdata[6:0];
            if (paddr == ADDR_LOCALS_LIMIT) r_locals_limit <= pwdata[6:0];
        end
    end

    always_comb begin
        case (paddr)
            ADDR_STACK_LIMIT:  prdata = {25'd0, r_stack_limit};
            ADDR_LOCALS_LIMIT: prdata = {25'd0, r_locals_limit};
            default:           prdata = '0;
        endcase
    end

    bsa_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_ch.valid), .o_ready(in_ch.ready),
        .i_opcode(in_ch.data.opcode), .i_immediate(in_ch.data.immediate),
        .i_local_index(in_ch.data.local_index),
        .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_instr(q_instr)
    );

    bsa_back #(.STACK_DEPTH(STACK_DEPTH), .LOCALS_DEPTH(LOCALS_DEPTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(q_valid), .o_q_pop(q_pop), .i_q_instr(q_instr),
        .i_stack_limit(r_stack_limit), .i_locals_limit(r_locals_limit),
        .o_valid(out_ch.valid), .i_ready(out_ch.ready), .o_result(res), .o_busy(busy)
    );

    assign out_ch.data.status        = res.status;
    assign out_ch.data.branch_taken  = res.branch_taken;
    assign out_ch.data.branch_offset = res.branch_offset;
    assign out_ch.data.top_value     = res.top_value;
    assign out_ch.data.depth_after   = res.depth_after;

    `include "bytecode_short_stack_alu_core_unit_assert.svh"

    `BSA_ASSERT_IMP(a_pop_when_idle, i_clk, i_rst_n, q_pop, q_valid && !busy)
    `BSA_ASSERT_IMP(a_status_range, i_clk, i_rst_n,
        out_ch.valid, out_ch.data.status <= ST_UNSUP)
    `BSA_ASSERT_IMP(a_err_no_branch, i_clk, i_rst_n,
        out_ch.valid && out_ch.data.status != ST_OK, !out_ch.data.branch_taken)
endmodule

// ===== hw/rtl/bsa_front.sv =====
// front part: accepts instruction beats, classifies them, two-entry queue
// depends on bsa_pkg
module bsa_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_opcode,
    input  logic [15:0]     i_immediate,
    input  logic [7:0]      i_local_index,
    output logic            o_q_valid,
    input  logic            i_q_pop,
    output bsa_pkg::t_instr o_q_instr
);
    import bsa_pkg::*;

    t_instr     r_q [2];
    logic [1:0] r_cnt;
    logic       r_wr, r_rd;
    logic       push, pop;

    assign o_ready   = (r_cnt != 2'd2);
    assign push      = i_valid && o_ready;
    assign pop       = i_q_pop && (r_cnt != 2'd0);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_instr = r_q[r_rd];

    // queue pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    // queue payload
    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wr] <= classify(i_opcode, i_immediate, i_local_index);
    end
endmodule

// ===== hw/rtl/bsa_muldiv.sv =====
// iterative multiply / signed divide unit, one bit per cycle
// depends on bsa_pkg
module bsa_muldiv (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_mul,
    input  logic        i_rem,
    input  logic [15:0] i_a,
    input  logic [15:0] i_b,
    output logic        o_done,
    output logic [15:0] o_res
);
    import bsa_pkg::*;

    logic        r_busy, r_done, r_mul, r_rem, r_negq, r_negr;
    logic [4:0]  r_cnt;
    logic [15:0] r_acc, r_quo, r_div;
    logic [16:0] trial;
    logic [15:0] abs_a, abs_b, shl_rem;

    assign abs_a   = i_a[15] ? 16'(-i_a) : i_a;
    assign abs_b   = i_b[15] ? 16'(-i_b) : i_b;
    assign shl_rem = {r_acc[14:0], r_quo[15]};
    assign trial   = {r_acc, r_quo[15]} - {1'b0, r_div};
    assign o_done  = r_done;
    always_comb begin
        if (r_mul) o_res = r_acc;
        else if (r_rem) o_res = r_negr ? 16'(-r_acc) : r_acc;
        else o_res = r_negq ? 16'(-r_quo) : r_quo;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd16;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: shift-add multiply or restoring divide
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mul  <= i_mul;
            r_rem  <= i_rem;
            r_acc  <= '0;
            r_negq <= i_a[15] ^ i_b[15];
            r_negr <= i_a[15];
            r_quo  <= i_mul ? i_a : abs_a;
            r_div  <= i_mul ? i_b : abs_b;
        end else if (r_busy) begin
            if (r_mul) begin
                r_acc <= {r_acc[14:0], 1'b0} + (r_quo[15] ? r_div : 16'd0);
                r_quo <= {r_quo[14:0], 1'b0};
            end else if (!trial[16]) begin
                r_acc <= trial[15:0];
                r_quo <= {r_quo[14:0], 1'b1};
            end else begin
                r_acc <= shl_rem;
                r_quo <= {r_quo[14:0], 1'b0};
            end
        end
    end
endmodule

// ===== hw/rtl/bsa_back.sv =====
// back part: checks, stack and locals update, result register
// depends on bsa_pkg and bsa_muldiv
module bsa_back #(
    parameter int unsigned STACK_DEPTH  = 64,
    parameter int unsigned LOCALS_DEPTH = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    output logic            o_q_pop,
    input  bsa_pkg::t_instr i_q_instr,
    input  logic [6:0]      i_stack_limit,
    input  logic [6:0]      i_locals_limit,
    output logic            o_valid,
    input  logic            i_ready,
    output bsa_pkg::t_result o_result,
    output logic            o_busy
);
    import bsa_pkg::*;

    localparam int unsigned SpW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned SaW = $clog2(STACK_DEPTH);
    localparam int unsigned LaW = $clog2(LOCALS_DEPTH);

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001, S_RD1 = 8'b00000010, S_RD2 = 8'b00000100,
        S_EXEC = 8'b00001000, S_MD = 8'b00010000, S_WR = 8'b00100000,
        S_RDT = 8'b01000000, S_TOP = 8'b10000000
    } t_state;

    t_state            r_state;
    t_instr            r_in;
    logic [SpW-1:0]    r_sp;
    logic [DataW-1:0]  r_a, r_b, r_loc, r_rd, r_res0;
    logic [2:0]        r_wi;
    logic [2:0]        r_status;
    logic              r_taken, r_ovalid, r_lzero;
    logic [DataW-1:0]  r_stk [STACK_DEPTH];
    logic [DataW-1:0]  r_loc_mem [LOCALS_DEPTH];
    logic [LOCALS_DEPTH-1:0] r_lv;
    t_result           r_out;

    logic [SpW+2:0]    slim, sp_w, need;
    logic [8:0]        llim;
    logic [2:0]        status;
    logic              md_start, md_done;
    logic [DataW-1:0]  md_res, bin_res, res_w;
    logic [SaW-1:0]    stk_raddr, stk_waddr;
    logic              stk_we, loc_we;
    logic [DataW-1:0]  loc_wdata;
    logic [LaW-1:0]    slot_a;
    logic              taken;
    logic [4:0]        sh;
    logic              slot_ok;

    assign o_valid  = r_ovalid;
    assign o_result = r_out;
    assign o_busy   = (r_state != S_IDLE);
    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid && !r_ovalid;
    assign slot_a   = r_in.slot[LaW-1:0];

    // limits and checks
    always_comb begin
        slim = (i_stack_limit < STACK_DEPTH) ? (SpW+3)'(i_stack_limit) : (SpW+3)'(STACK_DEPTH);
        llim = ({2'b0, i_locals_limit} < 9'(LOCALS_DEPTH)) ? {2'b0, i_locals_limit}
                                                           : 9'(LOCALS_DEPTH);
        sp_w = (SpW+3)'(r_sp);
        need = sp_w - (SpW+3)'(r_in.pops) + (SpW+3)'(r_in.pushes);
        slot_ok = ({1'b0, r_in.slot} < llim);
        status = ST_OK;
        if (r_in.kind == K_BAD) status = ST_UNSUP;
        else if ((SpW+3)'(r_in.pops) > sp_w) status = ST_UNDER;
        else if (r_in.pushes > r_in.pops && need > slim) status = ST_OVER;
        else if ((r_in.kind == K_LOAD || r_in.kind == K_STORE || r_in.kind == K_INC)
                 && !slot_ok) status = ST_LOCAL;
        else if (r_in.kind == K_BIN && (r_in.op == OP_SDIV || r_in.op == OP_SREM)
                 && r_b == '0) status = ST_DIV0;
    end

    // branch condition
    always_comb begin
        taken = 1'b0;
        case (r_in.kind)
            K_GOTO: taken = 1'b1;
            K_IF1: begin
                case (r_in.cond)
                    3'd0, 3'd6: taken = (r_b == '0);
                    3'd1, 3'd7: taken = (r_b != '0);
                    3'd2: taken = $signed(r_b) < 0;
                    3'd3: taken = $signed(r_b) >= 0;
                    3'd4: taken = $signed(r_b) > 0;
                    default: taken = $signed(r_b) <= 0;
                endcase
            end
            K_IF2: begin
                case (r_in.cond)
                    3'd0, 3'd2: taken = (r_a == r_b);
                    3'd1, 3'd3: taken = (r_a != r_b);
                    3'd4: taken = $signed(r_a) < $signed(r_b);
                    3'd5: taken = $signed(r_a) >= $signed(r_b);
                    3'd6: taken = $signed(r_a) > $signed(r_b);
                    default: taken = $signed(r_a) <= $signed(r_b);
                endcase
            end
            default: taken = 1'b0;
        endcase
    end

    // combinational alu ops
    always_comb begin
        sh = r_b[4:0] & SHIFT_MASK;
        case (r_in.op)
            OP_SADD:  bin_res = r_a + r_b;
            OP_SSUB:  bin_res = r_a - r_b;
            OP_SSHL:  bin_res = (sh >= 5'd16) ? '0 : r_a << sh[3:0];
            OP_SSHR:  bin_res = (sh >= 5'd16) ? {DataW{r_a[15]}}
                                              : 16'($signed(r_a) >>> sh[3:0]);
            OP_SUSHR: bin_res = (sh >= 5'd16) ? '0 : r_a >> sh[3:0];
            OP_SAND:  bin_res = r_a & r_b;
            OP_SOR:   bin_res = r_a | r_b;
            default:  bin_res = r_a ^ r_b;
        endcase
    end

    // value of the first pushed entry
    always_comb begin
        case (r_in.kind)
            K_PUSHC: res_w = r_in.val;
            K_LOAD:  res_w = r_lzero ? r_loc : '0;
            K_DUP:   res_w = r_b;
            K_DUP2:  res_w = r_a;
            K_NEG:   res_w = 16'(-r_b);
            K_S2B:   res_w = sx8(r_b);
            default: res_w = bin_res;
        endcase
    end

    assign md_start = (r_state == S_EXEC) && status == ST_OK && r_in.kind == K_BIN
        && (r_in.op == OP_SMUL || r_in.op == OP_SDIV || r_in.op == OP_SREM);

    bsa_muldiv u_md (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(md_start),
        .i_mul(r_in.op == OP_SMUL), .i_rem(r_in.op == OP_SREM),
        .i_a(r_a), .i_b(r_b), .o_done(md_done), .o_res(md_res)
    );

    // stack memory addressing
    always_comb begin
        stk_raddr = SaW'(r_sp - SpW'(1));
        case (r_state)
            S_RD1: stk_raddr = SaW'(r_sp - SpW'(2));
            default: stk_raddr = SaW'(r_sp - SpW'(1));
        endcase
        stk_waddr = SaW'(r_sp - SpW'(r_in.pops) + SpW'(r_wi));
        stk_we = (r_state == S_WR);
        loc_we = (r_state == S_EXEC) && status == ST_OK
                 && (r_in.kind == K_STORE || r_in.kind == K_INC);
        loc_wdata = (r_in.kind == K_STORE) ? r_b
                  : ((r_lzero ? r_loc : '0) + r_in.val);
    end

    // stack memory
    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stk[stk_waddr] <= (r_in.kind == K_DUP2)
                ? (r_wi[0] ? r_b : r_a)
                : ((r_wi == 3'd0) ? r_res0 : r_b);
        end
        r_rd <= r_stk[stk_raddr];
    end

    // locals memory with per-slot valid bits
    always_ff @(posedge i_clk) begin
        if (loc_we) r_loc_mem[slot_a] <= loc_wdata;
        r_loc <= r_loc_mem[slot_a];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_lv <= '0;
        else if (loc_we) r_lv[slot_a] <= 1'b1;
    end

    // sequencer: the read issued in idle returns top, rd1 returns next
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sp     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (o_q_pop) begin
                        r_in    <= i_q_instr;
                        r_state <= S_RD1;
                    end
                end
                S_RD1: begin
                    r_b     <= r_rd;
                    r_lzero <= r_lv[slot_a];
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    r_a     <= r_rd;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_status <= status;
                    r_taken  <= (status == ST_OK) && taken;
                    r_wi     <= '0;
                    r_res0   <= res_w;
                    if (status != ST_OK) r_state <= S_TOP;
                    else if (md_start) r_state <= S_MD;
                    else if (r_in.pushes != 3'd0) r_state <= S_WR;
                    else begin
                        r_sp    <= SpW'(r_sp - SpW'(r_in.pops));
                        r_state <= S_RDT;
                    end
                end
                S_MD: begin
                    if (md_done) begin
                        r_res0  <= md_res;
                        r_state <= S_WR;
                    end
                end
                S_WR: begin
                    r_wi <= r_wi + 3'd1;
                    if (r_wi + 3'd1 == r_in.pushes) begin
                        r_sp    <= SpW'(r_sp - SpW'(r_in.pops) + SpW'(r_in.pushes));
                        r_state <= S_RDT;
                    end
                end
                // read of the new top after the depth has moved
                S_RDT: r_state <= S_TOP;
                S_TOP: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
            if (r_state == S_TOP) begin
                r_ovalid <= 1'b1;
                r_out.status        <= r_status;
                r_out.branch_taken  <= r_taken;
                r_out.branch_offset <= (r_status == ST_OK) ? r_in.off : '0;
                r_out.top_value     <= (r_sp == '0) ? '0 : r_rd;
                r_out.depth_after   <= 7'(r_sp);
            end
        end
    end
endmodule

// ===== sim/bytecode_short_stack_alu_core_unit_tb.sv =====
// testbench for the bytecode short operand-stack alu core: directed, config and random runs
// predicts every result beat in a local stack machine model and checks them in order
// depends on bsa_pkg, bsa_if and the top level bytecode_short_stack_alu_core_unit
`timescale 1ns / 1ps

module bytecode_short_stack_alu_core_unit_tb;
    import bsa_pkg::*;

    // instruction beat as carried on the input channel
    typedef struct packed {
        logic [7:0]  opcode;
        logic [15:0] immediate;
        logic [7:0]  local_index;
    } t_instr_beat;

    localparam int STACK_SLOTS = 64;
    localparam int LOCAL_SLOTS = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 40;
    localparam int HOLD_CYCLES = 400;

    localparam logic [2:0] REG_STACK_LIMIT  = 3'd0;
    localparam logic [2:0] REG_LOCALS_LIMIT = 3'd1;

    // opcodes not named in the package
    localparam logic [7:0] OP_NOP        = 8'd0;
    localparam logic [7:0] OP_ACONST     = 8'd1;
    localparam logic [7:0] OP_SCONST_M1  = 8'd2;
    localparam logic [7:0] OP_SCONST_5   = 8'd8;
    localparam logic [7:0] OP_SLOAD      = 8'd21;
    localparam logic [7:0] OP_ALOAD      = 8'd22;
    localparam logic [7:0] OP_LOADN_LO   = 8'd24;
    localparam logic [7:0] OP_LOADN_HI   = 8'd31;
    localparam logic [7:0] OP_SSTORE     = 8'd40;
    localparam logic [7:0] OP_ASTORE     = 8'd41;
    localparam logic [7:0] OP_STOREN_LO  = 8'd43;
    localparam logic [7:0] OP_STOREN_HI  = 8'd50;
    localparam logic [7:0] OP_POP        = 8'd59;
    localparam logic [7:0] OP_POP2       = 8'd60;
    localparam logic [7:0] OP_DUP        = 8'd61;
    localparam logic [7:0] OP_DUP2       = 8'd62;
    localparam logic [7:0] OP_SXOR       = 8'd87;
    localparam logic [7:0] OP_IF1_LO     = 8'd96;
    localparam logic [7:0] OP_IF2_LO     = 8'd104;
    localparam logic [7:0] OP_IF_CMPLT   = 8'd108;
    localparam logic [7:0] OP_IF1W_LO    = 8'd152;
    localparam logic [7:0] OP_IF2W_LO    = 8'd160;
    localparam logic [7:0] OP_UNUSED     = 8'd255;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    bsa_if #(.T(t_instr_beat)) instr_ch ();
    bsa_if #(.T(t_result))     result_ch ();

    bytecode_short_stack_alu_core_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (instr_ch),
        .out_ch  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // machine state mirrored for prediction
    logic [15:0] model_stack [STACK_SLOTS];
    logic [15:0] model_locals [LOCAL_SLOTS];
    int          model_sp;
    int          model_stack_lim;
    int          model_locals_lim;

    t_result     expected_results [$];
    int          mismatches = 0;
    int          beats_sent;
    int          beats_checked = 0;
    int          config_writes;
    int          cycle_count = 0;
    int          src_idle_pct;
    int          snk_idle_pct = 0;
    int          hold_request = 0;
    int          hold_seen = 0;
    int          hold_left = 0;

    // clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     expected_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: random idling plus long holds on request
    always @(posedge i_clk) begin
        if (hold_request != hold_seen) begin
            hold_seen = hold_request;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            result_ch.ready <= 1'b0;
        end else begin
            result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            got = result_ch.data;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %p", got);
            end else begin
                want = expected_results.pop_front();
                beats_checked++;
                if (got.status !== want.status || got.branch_taken !== want.branch_taken ||
                    got.branch_offset !== want.branch_offset ||
                    got.top_value !== want.top_value ||
                    got.depth_after !== want.depth_after) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("beat %0d: expected %p, got %p", beats_checked, want, got);
                end
            end
        end
    end

    function automatic logic [15:0] sext8(input logic [15:0] v);
        return {{8{v[7]}}, v[7:0]};
    endfunction

    // comparison: 0 eq, 1 ne, 2 lt, 3 ge, 4 gt, 5 le
    function automatic bit compare_holds(input int c, input int x, input int y);
        case (c)
            0: return x == y;
            1: return x != y;
            2: return x < y;
            3: return x >= y;
            4: return x > y;
            default: return x <= y;
        endcase
    endfunction

    function automatic logic [15:0] alu_result(input logic [7:0] op, input int a, input int b);
        int ua;
        int sh;
        int r;
        ua = a & 32'hFFFF;
        sh = b & SHIFT_MASK;
        case (op)
            OP_SADD:  r = a + b;
            OP_SSUB:  r = a - b;
            OP_SMUL:  r = a * b;
            OP_SDIV:  r = a / b;
            OP_SREM:  r = a % b;
            OP_SSHL:  r = ua << sh;
            OP_SSHR:  r = a >>> sh;
            OP_SUSHR: r = ua >> sh;
            OP_SAND:  r = a & b;
            OP_SOR:   r = a | b;
            default:  r = a ^ b;
        endcase
        return r[15:0];
    endfunction

    // executes one instruction on the mirrored machine and returns its result beat
    function automatic t_result execute_instr(input t_instr_beat x);
        t_kind       k;
        logic [7:0]  op;
        logic [15:0] imm;
        logic [15:0] val;
        logic [15:0] off;
        logic [15:0] res [4];
        logic [2:0]  st;
        int          pops;
        int          pushes;
        int          slot;
        int          cnd;
        int          a;
        int          b;
        int          base;
        int          slim;
        int          llim;
        bit          taken;
        t_result     r;
        op = x.opcode;
        imm = x.immediate;
        k = K_BAD;
        pops = 0; pushes = 0; slot = 0; cnd = 0; val = '0; off = '0; taken = 0;
        a = 0; b = 0;
        slim = model_stack_lim < STACK_SLOTS ? model_stack_lim : STACK_SLOTS;
        llim = model_locals_lim < LOCAL_SLOTS ? model_locals_lim : LOCAL_SLOTS;

        // decode
        if (op == OP_NOP) k = K_NOP;
        else if (op == OP_ACONST) k = K_PUSHC;
        else if (op >= OP_SCONST_M1 && op <= OP_SCONST_5) begin
            k = K_PUSHC; val = 16'(int'(op) - 3);
        end else if (op == OP_BSPUSH) begin
            k = K_PUSHC; val = sext8(imm);
        end else if (op == OP_SSPUSH) begin
            k = K_PUSHC; val = imm;
        end else if (op == OP_SLOAD || op == OP_ALOAD) begin
            k = K_LOAD; slot = x.local_index;
        end else if (op >= OP_LOADN_LO && op <= OP_LOADN_HI) begin
            k = K_LOAD; slot = (op - OP_LOADN_LO) & 3;
        end else if (op == OP_SSTORE || op == OP_ASTORE) begin
            k = K_STORE; slot = x.local_index;
        end else if (op >= OP_STOREN_LO && op <= OP_STOREN_HI) begin
            k = K_STORE; slot = (op - OP_STOREN_LO) & 3;
        end else if (op == OP_POP) begin
            k = K_POP; pops = 1;
        end else if (op == OP_POP2) begin
            k = K_POP; pops = 2;
        end else if (op == OP_DUP) begin
            k = K_DUP; pops = 1; pushes = 2;
        end else if (op == OP_DUP2) begin
            k = K_DUP2; pops = 2; pushes = 4;
        end else if (op == OP_SNEG) begin
            k = K_NEG; pops = 1; pushes = 1;
        end else if (op >= OP_SADD && op <= OP_SXOR && op[0]) begin
            k = K_BIN; pops = 2; pushes = 1;
        end else if (op == OP_SINC) begin
            k = K_INC; slot = x.local_index; val = sext8(imm);
        end else if (op == OP_SINCW) begin
            k = K_INC; slot = x.local_index; val = imm;
        end else if (op == OP_S2B) begin
            k = K_S2B; pops = 1; pushes = 1;
        end else if (op >= OP_IF1_LO && op < OP_IF1_LO + 8) begin
            k = K_IF1; cnd = op - OP_IF1_LO; off = sext8(imm);
        end else if (op >= OP_IF2_LO && op < OP_IF2_LO + 8) begin
            k = K_IF2; cnd = op - OP_IF2_LO; off = sext8(imm);
        end else if (op == OP_GOTO) begin
            k = K_GOTO; off = sext8(imm);
        end else if (op >= OP_IF1W_LO && op < OP_IF1W_LO + 8) begin
            k = K_IF1; cnd = op - OP_IF1W_LO; off = imm;
        end else if (op >= OP_IF2W_LO && op < OP_IF2W_LO + 8) begin
            k = K_IF2; cnd = op - OP_IF2W_LO; off = imm;
        end else if (op == OP_GOTOW) begin
            k = K_GOTO; off = imm;
        end
        if (k == K_PUSHC || k == K_LOAD) pushes = 1;
        if (k == K_STORE || k == K_IF1) pops = 1;
        if (k == K_IF2) pops = 2;

        // status in priority order
        st = ST_OK;
        if (k == K_BAD) st = ST_UNSUP;
        else if (pops > model_sp) st = ST_UNDER;
        else if (pushes > pops && model_sp - pops + pushes > slim) st = ST_OVER;
        else if ((k == K_LOAD || k == K_STORE || k == K_INC) && slot >= llim) st = ST_LOCAL;
        else if (k == K_BIN && (op == OP_SDIV || op == OP_SREM) &&
                 model_stack[(model_sp - 1) % STACK_SLOTS] == 0) st = ST_DIV0;

        // execute only when clean
        if (st == ST_OK) begin
            base = model_sp - pops;
            if (pops >= 1) b = int'($signed(model_stack[(model_sp - 1) % STACK_SLOTS]));
            if (pops >= 2) a = int'($signed(model_stack[(model_sp - 2) % STACK_SLOTS]));
            case (k)
                K_PUSHC: res[0] = val;
                K_LOAD:  res[0] = model_locals[slot];
                K_STORE: model_locals[slot] = b[15:0];
                K_DUP: begin
                    res[0] = b[15:0]; res[1] = b[15:0];
                end
                K_DUP2: begin
                    res[0] = a[15:0]; res[2] = a[15:0];
                    res[1] = b[15:0]; res[3] = b[15:0];
                end
                K_BIN:   res[0] = alu_result(op, a, b);
                K_NEG:   res[0] = 16'(-b);
                K_S2B:   res[0] = sext8(b[15:0]);
                K_INC:   model_locals[slot] = model_locals[slot] + val;
                K_IF1: begin
                    if (cnd == 6) taken = (b == 0);
                    else if (cnd == 7) taken = (b != 0);
                    else taken = compare_holds(cnd, b, 0);
                end
                K_IF2:   taken = compare_holds(cnd < 4 ? (cnd & 1) : cnd - 2, a, b);
                K_GOTO:  taken = 1'b1;
                default: ;
            endcase
            for (int i = 0; i < pushes; i++)
                model_stack[(base + i) % STACK_SLOTS] = res[i];
            model_sp = base + pushes;
        end else begin
            off = '0;
        end

        r.status = st;
        r.branch_taken = taken;
        r.branch_offset = off;
        r.top_value = model_sp > 0 ? model_stack[(model_sp - 1) % STACK_SLOTS] : '0;
        r.depth_after = 7'(model_sp);
        return r;
    endfunction

    function automatic t_instr_beat mk_instr(input logic [7:0] op, input logic [15:0] imm,
                                             input logic [7:0] li);
        t_instr_beat x;
        x.opcode = op;
        x.immediate = imm;
        x.local_index = li;
        return x;
    endfunction

    // random instruction, mostly well-formed programs biased by the current depth
    function automatic t_instr_beat random_instr();
        int          r;
        logic [7:0]  op;
        logic [15:0] imm;
        logic [7:0]  li;
        r = $urandom_range(99);
        if (model_sp < 2 && r >= 35 && $urandom_range(99) < 60) r = $urandom_range(8, 34);
        if (r < 8) op = 8'($urandom_range(255));
        else if (r < 35) begin
            case ($urandom_range(4))
                0: op = 8'($urandom_range(OP_ACONST, OP_SCONST_5));
                1: op = OP_BSPUSH;
                2: op = OP_SSPUSH;
                3: op = $urandom_range(1) ? OP_SLOAD : OP_ALOAD;
                default: op = 8'($urandom_range(OP_LOADN_LO, OP_LOADN_HI));
            endcase
        end else if (r < 45) begin
            case ($urandom_range(3))
                0: op = $urandom_range(1) ? OP_SSTORE : OP_ASTORE;
                1: op = 8'($urandom_range(OP_STOREN_LO, OP_STOREN_HI));
                2: op = OP_SINC;
                default: op = OP_SINCW;
            endcase
        end else if (r < 70) begin
            case ($urandom_range(3))
                0: op = OP_SNEG;
                1: op = OP_S2B;
                default: op = 8'(OP_SADD + 2 * $urandom_range(11));
            endcase
        end else if (r < 80) op = 8'($urandom_range(OP_POP, OP_DUP2));
        else begin
            case ($urandom_range(5))
                0: op = 8'($urandom_range(OP_IF1_LO, OP_IF1_LO + 7));
                1: op = 8'($urandom_range(OP_IF2_LO, OP_IF2_LO + 7));
                2: op = 8'($urandom_range(OP_IF1W_LO, OP_IF1W_LO + 7));
                3: op = 8'($urandom_range(OP_IF2W_LO, OP_IF2W_LO + 7));
                4: op = OP_GOTO;
                default: op = OP_GOTOW;
            endcase
        end
        // small immediates make zero divisors, short shifts and equal compares likely
        imm = $urandom_range(3) == 0 ? 16'($urandom_range(6) - 3) : 16'($urandom_range(16'hFFFF));
        li = $urandom_range(3) == 0 ? 8'($urandom_range(255)) : 8'($urandom_range(7));
        return mk_instr(op, imm, li);
    endfunction

    // send one instruction beat, predict its result on acceptance
    task automatic send_instr(input t_instr_beat x);
        while ($urandom_range(99) < src_idle_pct) begin
            instr_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        instr_ch.valid <= 1'b1;
        instr_ch.data  <= x;
        do @(posedge i_clk); while (!instr_ch.ready);
        expected_results.push_back(execute_instr(x));
        beats_sent++;
    endtask

    // sender pauses until every expected beat has come back
    task automatic drain();
        instr_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(idx * 4);
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_STACK_LIMIT) model_stack_lim = value & 32'h7F;
        else model_locals_lim = value & 32'h7F;
        config_writes++;
    endtask

    task automatic send_random(input int n);
        repeat (n) send_instr(random_instr());
    endtask

    // extremes, arithmetic corner cases and every error status but overflow
    task automatic test_directed();
        send_instr(mk_instr(OP_POP, 16'h0, 8'd0));          // underflow on empty stack
        send_instr(mk_instr(OP_UNUSED, 16'hFFFF, 8'hFF));   // unsupported
        send_instr(mk_instr(OP_SLOAD, 16'h0, 8'd255));      // bad local
        send_instr(mk_instr(OP_SSPUSH, 16'h8000, 8'd0));
        send_instr(mk_instr(OP_SCONST_M1, 16'h0, 8'd0));
        send_instr(mk_instr(OP_SDIV, 16'h0, 8'd0));         // most negative / -1
        send_instr(mk_instr(OP_SSPUSH, 16'h8000, 8'd0));
        send_instr(mk_instr(OP_SCONST_M1, 16'h0, 8'd0));
        send_instr(mk_instr(OP_SREM, 16'h0, 8'd0));         // most negative rem -1
        send_instr(mk_instr(OP_SDIV, 16'h0, 8'd0));         // divide by zero
        send_instr(mk_instr(OP_POP, 16'h0, 8'd0));
        send_instr(mk_instr(OP_BSPUSH, 16'hFF10, 8'd0));    // shift count 16
        send_instr(mk_instr(OP_DUP2, 16'h0, 8'd0));
        send_instr(mk_instr(OP_SSHR, 16'h0, 8'd0));         // sign fill
        send_instr(mk_instr(OP_SUSHR, 16'h0, 8'd0));
        send_instr(mk_instr(OP_STOREN_LO, 16'h0, 8'd0));
        send_instr(mk_instr(OP_SINC, 16'h12FF, 8'd0));      // byte increment of -1
        send_instr(mk_instr(OP_SINCW, 16'h7FFF, 8'd1));
        send_instr(mk_instr(OP_LOADN_LO, 16'h0, 8'd0));
        send_instr(mk_instr(OP_IF1W_LO, 16'h8000, 8'd0));   // not taken, offset still shown
        send_instr(mk_instr(OP_GOTO, 16'h7F80, 8'd0));
        send_instr(mk_instr(OP_IF_CMPLT, 16'h0033, 8'd0));  // two-operand compare underflow
        send_instr(mk_instr(OP_SSTORE, 16'h0, 8'd63));
        send_instr(mk_instr(OP_GOTOW, 16'h7FFF, 8'd0));
        send_instr(mk_instr(OP_NOP, 16'hFFFF, 8'hFF));
        drain();
    endtask

    // several limit settings including the extremes, random programs under each
    task automatic test_limits();
        int stack_set [6]  = '{1, 64, 4, 2, 64, 3};
        int locals_set [6] = '{1, 64, 2, 64, 1, 5};
        for (int i = 0; i < 6; i++) begin
            write_reg(REG_STACK_LIMIT, stack_set[i]);
            write_reg(REG_LOCALS_LIMIT, locals_set[i]);
            send_random(40);
            drain();
        end
    endtask

    // receiver holds off long enough for the block to fill and stall its input
    task automatic test_backpressure();
        hold_request++;
        send_random(40);
        drain();
    endtask

    task automatic test_random_idling();
        src_idle_pct = 8;  snk_idle_pct = 82;
        send_random(120);
        src_idle_pct = 82; snk_idle_pct = 8;
        send_random(120);
        src_idle_pct = 0;  snk_idle_pct = 0;
        send_random(120);
        drain();
    endtask

    initial begin
        model_sp = 0;
        model_stack_lim = 64;
        model_locals_lim = 64;
        for (int i = 0; i < LOCAL_SLOTS; i++) model_locals[i] = '0;
        beats_sent = 0; config_writes = 0;
        src_idle_pct = 0;
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        instr_ch.valid = 1'b0;
        instr_ch.data = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (DRAIN_WAIT) @(posedge i_clk);

        test_directed();
        test_limits();
        test_backpressure();
        test_random_idling();

        $display("%0d instructions sent, %0d results checked, %0d register writes",
                 beats_sent, beats_checked, config_writes);
        $display("covered errors, wrapping arithmetic, branches, limit sweeps and stalls");
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     expected_results.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== bytecode_short_stack_alu_core_unit.f =====
+incdir+hw/rtl
hw/rtl/bsa_pkg.sv
hw/rtl/bsa_if.sv
hw/rtl/bsa_front.sv
hw/rtl/bsa_muldiv.sv
hw/rtl/bsa_back.sv
hw/rtl/bytecode_short_stack_alu_core_unit.sv
sim/bytecode_short_stack_alu_core_unit_tb.sv
